// ===== rtl/tcw_pkg.sv =====
// shared constants, types and address helper for the text console writer
// no dependencies; imported by text_console_writer

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int XW     = $clog2(COLUMNS);
    localparam int YW     = $clog2(ROWS);
    localparam int AW     = $clog2(CELLS);
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BLOCK     = 8'hDB;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_SETCUR = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BS_WRITE,
        ST_READ_WAIT,
        ST_COPY,
        ST_FILL
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y,
                                                input logic [XW-1:0] x);
        cell_addr = AW'(int'(y) * COLUMNS + int'(x));
    endfunction

endpackage

// ===== rtl/tcw_cell_ram.sv =====
// simple dual-port cell store: one write port, one registered read port
// no package dependencies

module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/text_console_writer.sv =====
// text console engine: cursor control plus character-cell store sequencer
// depends on tcw_pkg and tcw_cell_ram

// usage
// - a command transaction is taken at a rising edge with start high and busy low;
//   operation selects put character, set cursor, clear screen or read cell
// - every command gives exactly one result: done is high for one cycle and the
//   cursor, its linear offset and the read cell sit on the result ports in
//   that cycle; the receiver cannot stall, so nothing waits on it
// - how each command runs from acceptance to done:
//     set cursor, out-of-range read, printable / tab / cr / lf put: done next cycle
//     in-range read and backspace (read-modify-write of one cell): via ST_READ_WAIT
//     or ST_BS_WRITE; clear screen: one cell write a cycle over the whole store
//     put that scrolls: the put itself (with ST_BS_WRITE for a backspace), then
//     pipelined row copy and bottom-row fill
// - busy is high while the sequencer is out of idle; a command that completes
//   from idle keeps busy low, so a new one can follow in the next cycle
// - the single write port of the cell store sets the cost of scroll and clear
// - after reset the block zeroes all CELLS cells (2000 at 80x25) one cell a
//   cycle with busy high; no result is given for that pass
// - only one command is in flight at a time; the store can still see a read and
//   a write of the same cell in one cycle, as the unused read address rests on ptr

module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_code,
    input  logic [7:0]  colour,
    input  logic [6:0]  pos_x,
    input  logic [4:0]  pos_y,
    output logic        done,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic [10:0] cursor_offset,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_colour
);

    import tcw_pkg::*;

    state_t state_reg, state_next;

    logic [XW-1:0]     cursor_x_reg, cursor_x_next;
    logic [YW-1:0]     cursor_y_reg, cursor_y_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]     pipe_addr_reg, pipe_addr_next;
    logic [AW-1:0]     bs_addr_reg, bs_addr_next;
    logic              scroll_reg, scroll_next;
    logic [CELL_W-1:0] fill_reg, fill_next;
    logic              done_reg, done_next;
    logic [7:0]        cell_char_reg, cell_char_next;
    logic [7:0]        cell_colour_reg, cell_colour_next;

    // cell store ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // decoded command
    logic   accept;
    op_t    op;

    // put-character cursor arithmetic, one bit of headroom for wrap / scroll
    logic [XW:0] put_x, wrap_x;
    logic [YW:0] put_y, wrap_y, final_y;
    logic        put_write, put_bs, put_scroll;

    // set-cursor saturation and read range check
    logic          px_in, py_in;
    logic [XW-1:0] sat_x;
    logic [YW-1:0] sat_y;

    assign accept = start && (state_reg == ST_IDLE);
    assign op     = op_t'(operation);

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // cursor movement for a put: character effect, then wrap, then scroll
    always_comb
    begin
        put_x     = {1'b0, cursor_x_reg};
        put_y     = {1'b0, cursor_y_reg};
        put_write = 1'b0;
        put_bs    = 1'b0;
        unique case (char_code)
            CH_BACKSPACE:
            begin
                if (cursor_x_reg != '0)
                begin
                    put_x  = put_x - 1'b1;
                    put_bs = 1'b1;
                end
            end
            CH_TAB:
            begin
                put_x = put_x + (XW+1)'(4);
            end
            CH_CR:
            begin
                put_x = '0;
            end
            CH_LF:
            begin
                put_x = '0;
                put_y = put_y + 1'b1;
            end
            default:
            begin
                put_write = 1'b1;
                put_x     = put_x + 1'b1;
            end
        endcase

        if (put_x >= (XW+1)'(COLUMNS))
        begin
            wrap_x = '0;
            wrap_y = put_y + 1'b1;
        end
        else
        begin
            wrap_x = put_x;
            wrap_y = put_y;
        end

        put_scroll = (wrap_y >= (YW+1)'(ROWS - 1));
        final_y    = put_scroll ? (wrap_y - 1'b1) : wrap_y;
    end

    always_comb
    begin
        px_in = ({1'b0, pos_x} < 8'(COLUMNS));
        py_in = ({1'b0, pos_y} < 6'(ROWS));
        sat_x = px_in ? XW'(pos_x) : XW'(COLUMNS - 1);
        sat_y = py_in ? YW'(pos_y) : YW'(ROWS - 1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (!pipe_valid_reg && ptr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        OP_PUT:
                        begin
                            if (put_bs)
                            begin
                                state_next = ST_BS_WRITE;
                            end
                            else if (put_scroll)
                            begin
                                state_next = ST_COPY;
                            end
                        end
                        OP_SETCUR:
                        begin
                            state_next = ST_IDLE;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_FILL;
                        end
                        OP_READ:
                        begin
                            if (px_in && py_in)
                            begin
                                state_next = ST_READ_WAIT;
                            end
                        end
                    endcase
                end
            end
            ST_BS_WRITE:
            begin
                state_next = scroll_reg ? ST_COPY : ST_IDLE;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!pipe_valid_reg && ptr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        ptr_next         = ptr_reg;
        pipe_valid_next  = 1'b0;
        pipe_addr_next   = pipe_addr_reg;
        bs_addr_next     = bs_addr_reg;
        scroll_next      = scroll_reg;
        fill_next        = fill_reg;
        done_next        = 1'b0;
        cell_char_next   = cell_char_reg;
        cell_colour_next = cell_colour_reg;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = fill_reg;
        mem_raddr        = ptr_reg;

        // a copy read issued last cycle lands now and owns the write port
        if (pipe_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pipe_addr_reg;
            mem_wdata = mem_rdata;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                if (!pipe_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg;
                    mem_wdata = '0;
                    if (ptr_reg != AW'(CELLS - 1))
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_char_next   = '0;
                    cell_colour_next = '0;
                    unique case (op)
                        OP_PUT:
                        begin
                            cursor_x_next = XW'(wrap_x);
                            cursor_y_next = YW'(final_y);
                            scroll_next   = put_scroll;
                            fill_next     = {colour, CH_SPACE};
                            ptr_next      = AW'(COLUMNS);
                            bs_addr_next  = cell_addr(cursor_y_reg, XW'(put_x));
                            mem_raddr     = cell_addr(cursor_y_reg, XW'(put_x));
                            if (put_write)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(cursor_y_reg, cursor_x_reg);
                                mem_wdata = {colour, char_code};
                            end
                            done_next = !put_bs && !put_scroll;
                        end
                        OP_SETCUR:
                        begin
                            cursor_x_next = sat_x;
                            cursor_y_next = sat_y;
                            done_next     = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cursor_x_next = '0;
                            cursor_y_next = '0;
                            fill_next     = {colour, CH_BLOCK};
                            ptr_next      = '0;
                        end
                        OP_READ:
                        begin
                            mem_raddr = cell_addr(YW'(pos_y), XW'(pos_x));
                            done_next = !(px_in && py_in);
                        end
                    endcase
                end
            end
            ST_BS_WRITE:
            begin
                // blank the character byte, keep the colour
                mem_we    = 1'b1;
                mem_waddr = bs_addr_reg;
                mem_wdata = {mem_rdata[CELL_W-1:8], 8'h00};
                done_next = !scroll_reg;
            end
            ST_READ_WAIT:
            begin
                cell_char_next   = mem_rdata[7:0];
                cell_colour_next = mem_rdata[CELL_W-1:8];
                done_next        = 1'b1;
            end
            ST_COPY:
            begin
                // read one cell, write it one row up in the next cycle
                mem_raddr       = ptr_reg;
                pipe_valid_next = 1'b1;
                pipe_addr_next  = ptr_reg - AW'(COLUMNS);
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next = AW'((ROWS - 1) * COLUMNS);
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                if (!pipe_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg;
                    mem_wdata = fill_reg;
                    if (ptr_reg == AW'(CELLS - 1))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            ptr_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            scroll_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            ptr_reg        <= ptr_next;
            pipe_valid_reg <= pipe_valid_next;
            scroll_reg     <= scroll_next;
            done_reg       <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        pipe_addr_reg   <= pipe_addr_next;
        bs_addr_reg     <= bs_addr_next;
        fill_reg        <= fill_next;
        cell_char_reg   <= cell_char_next;
        cell_colour_reg <= cell_colour_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign cursor_column = 7'(cursor_x_reg);
    assign cursor_row    = 5'(cursor_y_reg);
    assign cursor_offset = 11'(int'(cursor_y_reg) * COLUMNS + int'(cursor_x_reg));
    assign cell_char     = cell_char_reg;
    assign cell_colour   = cell_colour_reg;

endmodule
